// ===== rtl/stc_pkg.sv =====
// shared types, constants and tanh table generator for the stereo tanh soft clipper
package stc_pkg;

	localparam int SAMPLE_BITS        = 24;
	localparam int TANH_TABLE_ENTRIES = 256;
	localparam int LANE_LATENCY       = 10;

	localparam int DRIVE_BITS     = 22;
	localparam int MAKEUP_BITS    = 18;
	localparam int MIX_BITS       = 17;
	localparam int CFG_DATA_BITS  = 22;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE_GAIN  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAKEUP_GAIN = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WET_MIX     = 2'd2;

	localparam logic [DRIVE_BITS-1:0]  DRIVE_RESET  = 22'd65536;
	localparam logic [MAKEUP_BITS-1:0] MAKEUP_RESET = 18'd65536;
	localparam logic [MIX_BITS-1:0]    MIX_ONE      = 17'd65536;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
	} out_word_t;

	typedef struct packed {
		logic [DRIVE_BITS-1:0]  drive_gain;
		logic [MAKEUP_BITS-1:0] makeup_gain;
		logic [MIX_BITS-1:0]    wet_mix;
	} gains_t;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	// shift-subtract divide, elaboration only
	function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-f) in q30 for f in [0, 1] in q30
	function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
		logic [63:0] term;
		logic [63:0] sum;
		term = Q30_ONE;
		sum  = Q30_ONE;
		for (int i = 1; i < 24; i++) begin
			term = udiv(term * f, 64'(i) << 30);
			sum  = sum + term;
		end
		return udiv((64'd1 << 60) + (sum >> 1), sum);
	endfunction

	// tanh(8k/n) in unsigned q31
	function automatic logic [31:0] tanh_point(input int k, input int n);
		logic [63:0] em1;
		logic [63:0] y;
		logic [63:0] whole;
		logic [63:0] part;
		logic [63:0] r;
		logic [63:0] t;
		logic [63:0] den;
		logic [63:0] entry;
		em1   = exp_neg_frac(Q30_ONE);
		y     = udiv(((64'd16 * 64'(k)) << 30) + (64'(n) >> 1), 64'(n));
		whole = y >> 30;
		part  = y & (Q30_ONE - 64'd1);
		r     = Q30_ONE;
		for (int i = 0; i < 17; i++) begin
			if (64'(i) < whole) begin
				r = (r * em1 + (64'd1 << 29)) >> 30;
			end
		end
		t = (r * exp_neg_frac(part) + (64'd1 << 29)) >> 30;
		if (t > Q30_ONE) begin
			t = Q30_ONE;
		end
		den   = Q30_ONE + t;
		entry = udiv(((Q30_ONE - t) << 31) + (den >> 1), den);
		return entry[31:0];
	endfunction

endpackage

// ===== rtl/stc_lane.sv =====
// one channel of the shaping pipeline: drive, table tanh, makeup, dry/wet mix, saturation
module stc_lane #(
	parameter int Entries = stc_pkg::TANH_TABLE_ENTRIES
) (
	input  logic                                    clk,
	input  logic                                    en,
	input  stc_pkg::gains_t                         gains,
	input  logic signed [stc_pkg::SAMPLE_BITS-1:0]  sample,
	output logic signed [stc_pkg::SAMPLE_BITS-1:0]  result
);

	localparam int B  = stc_pkg::SAMPLE_BITS;
	localparam int AS = B + 18;
	localparam int AW = B + 21;
	localparam int IW = $clog2(Entries);
	localparam int RW = $clog2(Entries + 1);
	localparam int PW = AS + IW;
	localparam int SH = 32 - B;
	localparam logic [32:0] RND = (33'd1 << SH) >> 1;
	localparam logic [B-1:0] MAG_ONE = {1'b1, {(B-1){1'b0}}};
	localparam logic [B-1:0] OUT_MIN = {1'b1, {(B-1){1'b0}}};
	localparam logic [B-1:0] OUT_MAX = {1'b0, {(B-1){1'b1}}};

	logic [31:0] rom [Entries+1];

	for (genvar k = 0; k <= Entries; k++) begin : g_rom
		localparam logic [31:0] POINT = stc_pkg::tanh_point(k, Entries);
		assign rom[k] = POINT;
	end

	logic signed [B+22:0] p_s1;
	logic [B+22:0]        p_u;
	logic [B+22:0]        p_mag;
	logic [AW-1:0]        a_s2;
	logic                 neg_s2, neg_s3, neg_s4, neg_s5;
	logic                 sat_s3, sat_s4, sat_s5;
	logic [PW-1:0]        pos_s3;
	logic [IW-1:0]        idx;
	logic [RW-1:0]        addr0;
	logic [RW-1:0]        addr1;
	logic [31:0]          t0_s4, t1_s4, t0_s5;
	logic [15:0]          fr_s4;
	logic [31:0]          diff;
	logic [47:0]          prod_s5;
	logic [48:0]          ip;
	logic [32:0]          y;
	logic [32:0]          yr;
	logic [B-1:0]         mag;
	logic signed [B:0]    s_pos;
	logic signed [B:0]    s_s6;
	logic signed [B+19:0] wp_s7;
	logic signed [B+19:0] wet_full;
	logic signed [B+3:0]  wet;
	logic signed [B+4:0]  d_s8;
	logic signed [B+22:0] mp_s9;
	logic signed [B+22:0] rs;
	logic signed [B+22:0] sum;
	logic [B-1:0]         hi;
	logic                 fits;
	logic signed [B-1:0]  res_s10;
	logic signed [B-1:0]  x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7, x_s8, x_s9;

	assign p_u   = p_s1;
	assign p_mag = p_s1[B+22] ? (~p_u + (B+23)'(1)) : p_u;

	assign idx   = pos_s3[PW-1:AS];
	assign addr0 = RW'(idx);
	assign addr1 = addr0 + RW'(1);

	assign diff  = t1_s4 - t0_s4;

	assign ip    = {1'b0, prod_s5} + 49'd32768;
	assign y     = {1'b0, t0_s5} + ip[48:16];
	assign yr    = y + RND;
	assign mag   = sat_s5 ? MAG_ONE : yr[31:SH];
	assign s_pos = $signed({1'b0, mag});

	assign wet_full = (wp_s7 + $signed((B+20)'(32768))) >>> 16;
	assign wet      = wet_full[B+3:0];

	assign rs   = (mp_s9 + $signed((B+23)'(32768))) >>> 16;
	assign sum  = rs + (B+23)'(x_s9);
	assign hi   = sum[B+22:B-1];
	assign fits = (&hi) | ~(|hi);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= sample * $signed({1'b0, gains.drive_gain});
			x_s1    <= sample;

			a_s2    <= p_mag[AW-1:0];
			neg_s2  <= p_s1[B+22];
			x_s2    <= x_s1;

			sat_s3  <= |a_s2[AW-1:AS];
			pos_s3  <= PW'(a_s2[AS-1:0]) * PW'(Entries);
			neg_s3  <= neg_s2;
			x_s3    <= x_s2;

			t0_s4   <= rom[addr0];
			t1_s4   <= rom[addr1];
			fr_s4   <= pos_s3[AS-1:AS-16];
			sat_s4  <= sat_s3;
			neg_s4  <= neg_s3;
			x_s4    <= x_s3;

			prod_s5 <= {16'd0, diff} * {32'd0, fr_s4};
			t0_s5   <= t0_s4;
			sat_s5  <= sat_s4;
			neg_s5  <= neg_s4;
			x_s5    <= x_s4;

			s_s6    <= neg_s5 ? -s_pos : s_pos;
			x_s6    <= x_s5;

			wp_s7   <= s_s6 * $signed({1'b0, gains.makeup_gain});
			x_s7    <= x_s6;

			d_s8    <= (B+5)'(wet) - (B+5)'(x_s7);
			x_s8    <= x_s7;

			mp_s9   <= d_s8 * $signed({1'b0, gains.wet_mix});
			x_s9    <= x_s8;

			res_s10 <= fits ? sum[B-1:0] : (sum[B+22] ? OUT_MIN : OUT_MAX);
		end
	end

	assign result = res_s10;

endmodule

// ===== rtl/stc_merge.sv =====
// joins both lane results into one output word behind an output register and skid stage
module stc_merge (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   up_valid,
	output logic                                   up_ready,
	input  logic signed [stc_pkg::SAMPLE_BITS-1:0] left_res,
	input  logic signed [stc_pkg::SAMPLE_BITS-1:0] right_res,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output stc_pkg::out_word_t                     out_word
);

	stc_pkg::out_word_t up_word;
	stc_pkg::out_word_t out_q;
	stc_pkg::out_word_t skid_q;
	logic               out_valid_q;
	logic               skid_valid_q;

	assign up_word.left_out  = left_res;
	assign up_word.right_out = right_res;
	assign up_ready          = ~skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= up_valid;
			end
		end else if (up_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (up_valid) begin
				out_q <= up_word;
			end
		end else if (up_valid && !skid_valid_q) begin
			skid_q <= up_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

// ===== rtl/stereo_tanh_soft_clipper_core.sv =====
// top level of the stereo tanh soft clipper
// Takes one stereo word per cycle while in_ready is high and returns one shaped word per
// cycle while out_ready is high, in order. Each channel runs through its own ten-stage
// lane (drive multiply, table tanh with linear interpolation, makeup multiply, dry/wet
// mix, saturation); the lane results reach the output through the output register, or
// through the skid stage while the output stalls. The two table reads of each lane share
// one registered stage, and the output register with its skid stage keeps input ready
// registered, so back-pressure costs no throughput until both are full. Gains and mix are
// plain write registers and should be changed only while the block is empty.
module stereo_tanh_soft_clipper_core #(
	parameter int TANH_TABLE_ENTRIES = stc_pkg::TANH_TABLE_ENTRIES
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  stc_pkg::in_word_t                     in_word,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output stc_pkg::out_word_t                    out_word,
	input  logic                                  cfg_we,
	input  logic [stc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [stc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int LAT = stc_pkg::LANE_LATENCY;

	logic [stc_pkg::DRIVE_BITS-1:0]  drive_q;
	logic [stc_pkg::MAKEUP_BITS-1:0] makeup_q;
	logic [stc_pkg::MIX_BITS-1:0]    mix_q;
	stc_pkg::gains_t                 gains;
	logic [LAT-1:0]                  vld_q;
	logic                            en;
	logic signed [stc_pkg::SAMPLE_BITS-1:0] left_res;
	logic signed [stc_pkg::SAMPLE_BITS-1:0] right_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q  <= stc_pkg::DRIVE_RESET;
			makeup_q <= stc_pkg::MAKEUP_RESET;
			mix_q    <= stc_pkg::MIX_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				stc_pkg::REG_DRIVE_GAIN: begin
					drive_q <= cfg_data[stc_pkg::DRIVE_BITS-1:0];
				end
				stc_pkg::REG_MAKEUP_GAIN: begin
					makeup_q <= cfg_data[stc_pkg::MAKEUP_BITS-1:0];
				end
				stc_pkg::REG_WET_MIX: begin
					mix_q <= cfg_data[stc_pkg::MIX_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign gains.drive_gain  = drive_q;
	assign gains.makeup_gain = makeup_q;
	assign gains.wet_mix     = (mix_q > stc_pkg::MIX_ONE) ? stc_pkg::MIX_ONE : mix_q;

	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	stc_lane #(
		.Entries (TANH_TABLE_ENTRIES)
	) u_lane_left (
		.clk    (clk),
		.en     (en),
		.gains  (gains),
		.sample (in_word.left_in),
		.result (left_res)
	);

	stc_lane #(
		.Entries (TANH_TABLE_ENTRIES)
	) u_lane_right (
		.clk    (clk),
		.en     (en),
		.gains  (gains),
		.sample (in_word.right_in),
		.result (right_res)
	);

	stc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (vld_q[LAT-1]),
		.up_ready  (en),
		.left_res  (left_res),
		.right_res (right_res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

// ===== rtl/stc_checker.sv =====
// port-level checks for the stereo tanh soft clipper, bound to the top level
module stc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input stc_pkg::out_word_t  out_word
);

	localparam logic [4:0] CAP = 5'(stc_pkg::LANE_LATENCY + 2);

	logic [4:0] cnt_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 5'(in_acc) - 5'(out_acc);
		end
	end

	a_out_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cnt_q != 5'd0))
		else $error("output word with no accepted input behind it");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP)
		else $error("more words in flight than the pipeline holds");

	a_ready_low_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled while output is empty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
		else $error("stalled output word changed or dropped");

endmodule

bind stereo_tanh_soft_clipper_core stc_checker u_stc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

// ===== verif/stereo_tanh_soft_clipper_core_test.sv =====
// testbench for the stereo tanh soft clipper core: directed table and random words checked against a bit-exact predictor
module stereo_tanh_soft_clipper_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef longint unsigned u64_t;
	typedef logic signed [stc_pkg::SAMPLE_BITS-1:0] sample_t;
	typedef logic [stc_pkg::CFG_DATA_BITS-1:0]      cfg_data_t;

	localparam int FRAC        = stc_pkg::SAMPLE_BITS - 1;
	localparam int ARG_SHIFT   = FRAC + 19;
	localparam int ENTRIES     = stc_pkg::TANH_TABLE_ENTRIES;
	localparam int WATCHDOG    = 2000;
	localparam int HOLD_CYCLES = 240;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 166;
	localparam int NUM_CASES   = 20;

	localparam u64_t ONE_Q30 = u64_t'(1) << 30;

	localparam logic [stc_pkg::CFG_INDEX_BITS-1:0] REG_SPARE  = 2'd3;
	localparam logic [stc_pkg::DRIVE_BITS-1:0]     DRIVE_MAX  = '1;
	localparam logic [stc_pkg::MAKEUP_BITS-1:0]    MAKEUP_MAX = '1;
	localparam logic [stc_pkg::MIX_BITS-1:0]       MIX_OVER   = '1;

	localparam logic [stc_pkg::DRIVE_BITS-1:0]  DRIVE_RESET  = stc_pkg::DRIVE_RESET;
	localparam logic [stc_pkg::MAKEUP_BITS-1:0] MAKEUP_RESET = stc_pkg::MAKEUP_RESET;
	localparam logic [stc_pkg::MIX_BITS-1:0]    MIX_ONE      = stc_pkg::MIX_ONE;

	localparam sample_t S_MAX = {1'b0, {FRAC{1'b1}}};
	localparam sample_t S_MIN = {1'b1, {FRAC{1'b0}}};

	typedef struct packed {
		logic [stc_pkg::DRIVE_BITS-1:0]  drive;
		logic [stc_pkg::MAKEUP_BITS-1:0] makeup;
		logic [stc_pkg::MIX_BITS-1:0]    mix;
		sample_t                         left_smp;
		sample_t                         right_smp;
		logic                            typed;
		sample_t                         want_left;
		sample_t                         want_right;
	} clip_case_t;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  in_valid;
	logic                                  in_ready;
	stc_pkg::in_word_t                     in_word;
	logic                                  out_valid;
	logic                                  out_ready;
	stc_pkg::out_word_t                    out_word;
	logic                                  cfg_we;
	logic [stc_pkg::CFG_INDEX_BITS-1:0]    cfg_index;
	cfg_data_t                             cfg_data;

	logic [stc_pkg::DRIVE_BITS-1:0]  cur_drive  = DRIVE_RESET;
	logic [stc_pkg::MAKEUP_BITS-1:0] cur_makeup = MAKEUP_RESET;
	logic [stc_pkg::MIX_BITS-1:0]    cur_mix    = MIX_ONE;

	u64_t               tanh_q31 [ENTRIES+1];
	stc_pkg::out_word_t shaped_q [$];
	stc_pkg::out_word_t want;
	int                 mismatches     = 0;
	int                 send_idle_pct  = 0;
	int                 recv_stall_pct = 0;
	int                 hold_left      = 0;
	logic               hold_req       = 1'b0;
	int                 quiet_cycles   = 0;

	clip_case_t cases [NUM_CASES] = '{
		'{DRIVE_RESET, MAKEUP_RESET, MIX_ONE, 24'sh0, 24'sh0, 1'b1, 24'sh0, 24'sh0},
		'{DRIVE_RESET, MAKEUP_RESET, MIX_ONE, S_MAX, S_MIN, 1'b0, 24'sh0, 24'sh0},
		'{DRIVE_RESET, MAKEUP_RESET, MIX_ONE, 24'sh1, 24'shffffff, 1'b0, 24'sh0, 24'sh0},
		'{DRIVE_RESET, MAKEUP_RESET, MIX_ONE, 24'sh400000, 24'shc00000, 1'b0, 24'sh0, 24'sh0},
		'{DRIVE_MAX, MAKEUP_RESET, MIX_ONE, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
		'{DRIVE_MAX, MAKEUP_RESET, MIX_ONE, 24'sh0, 24'sh0, 1'b1, 24'sh0, 24'sh0},
		'{DRIVE_MAX, MAKEUP_RESET, MIX_ONE, 24'sh1, 24'shffffff, 1'b0, 24'sh0, 24'sh0},
		'{DRIVE_MAX, MAKEUP_RESET, MIX_ONE, 24'sh100000, 24'shf00000, 1'b0, 24'sh0, 24'sh0},
		'{DRIVE_MAX, MAKEUP_RESET, MIX_ONE, 24'sh100001, 24'shefffff, 1'b1, S_MAX, S_MIN},
		'{22'd0, MAKEUP_MAX, MIX_ONE, S_MAX, S_MIN, 1'b1, 24'sh0, 24'sh0},
		'{22'd0, MAKEUP_MAX, MIX_ONE, 24'sh123456, 24'shedcba9, 1'b1, 24'sh0, 24'sh0},
		'{DRIVE_MAX, MAKEUP_MAX, MIX_OVER, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
		'{DRIVE_MAX, MAKEUP_MAX, MIX_OVER, 24'sh003039, 24'shfffcf7, 1'b0, 24'sh0, 24'sh0},
		'{DRIVE_RESET, 18'd0, 17'd0, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
		'{DRIVE_RESET, 18'd0, 17'd0, 24'shffffff, 24'sh1, 1'b1, 24'shffffff, 24'sh1},
		'{DRIVE_RESET, 18'd0, 17'd0, 24'sh2dc6c0, 24'shd23940, 1'b0, 24'sh0, 24'sh0},
		'{22'd196608, 18'd32768, 17'd32768, 24'sh2dc6c0, 24'shd23940, 1'b0, 24'sh0, 24'sh0},
		'{22'd196608, 18'd32768, 17'd32768, S_MAX, 24'shffffff, 1'b0, 24'sh0, 24'sh0},
		'{22'd1, 18'd1, 17'd1, S_MAX, S_MIN, 1'b0, 24'sh0, 24'sh0},
		'{22'd1, 18'd1, 17'd1, 24'sh000400, 24'shfffc00, 1'b0, 24'sh0, 24'sh0}
	};

	stereo_tanh_soft_clipper_core uut (.*);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic u64_t exp_neg_q30(input u64_t f);
		u64_t term;
		u64_t sum;
		term = ONE_Q30;
		sum  = ONE_Q30;
		for (int i = 1; i < 24; i++) begin
			term = (term * f) / (u64_t'(i) << 30);
			sum  = sum + term;
		end
		return ((u64_t'(1) << 60) + sum / 2) / sum;
	endfunction

	function automatic void build_tanh_table();
		u64_t em1;
		u64_t y;
		u64_t whole;
		u64_t part;
		u64_t r;
		u64_t t;
		u64_t den;
		em1 = exp_neg_q30(ONE_Q30);
		for (int k = 0; k <= ENTRIES; k++) begin
			y     = ((u64_t'(16 * k) << 30) + u64_t'(ENTRIES / 2)) / u64_t'(ENTRIES);
			whole = y >> 30;
			part  = y & (ONE_Q30 - 1);
			r     = ONE_Q30;
			for (u64_t i = 0; i < whole; i++) begin
				r = (r * em1 + (ONE_Q30 >> 1)) >> 30;
			end
			t = (r * exp_neg_q30(part) + (ONE_Q30 >> 1)) >> 30;
			if (t > ONE_Q30) begin
				t = ONE_Q30;
			end
			den         = ONE_Q30 + t;
			tanh_q31[k] = (((ONE_Q30 - t) << 31) + den / 2) / den;
		end
	endfunction

	function automatic sample_t clip_sample(input sample_t smp);
		longint x;
		longint p;
		longint mag;
		longint s;
		longint wet;
		longint mixf;
		longint o;
		u64_t   a;
		u64_t   pos;
		u64_t   idx;
		u64_t   fr;
		u64_t   t0;
		u64_t   t1;
		u64_t   y;
		x = smp;
		p = x * longint'(cur_drive);
		a = (p < 0) ? u64_t'(-p) : u64_t'(p);
		if (a >= (u64_t'(1) << ARG_SHIFT)) begin
			mag = longint'(1) << FRAC;
		end else begin
			pos = a * u64_t'(ENTRIES);
			idx = pos >> ARG_SHIFT;
			fr  = (pos & ((u64_t'(1) << ARG_SHIFT) - 1)) >> (ARG_SHIFT - 16);
			if (idx >= u64_t'(ENTRIES)) begin
				idx = u64_t'(ENTRIES - 1);
			end
			t0  = tanh_q31[idx];
			t1  = tanh_q31[idx + 1];
			y   = t0 + (((t1 - t0) * fr + (u64_t'(1) << 15)) >> 16);
			mag = longint'((y + (u64_t'(1) << (30 - FRAC))) >> (31 - FRAC));
		end
		s    = (p < 0) ? -mag : mag;
		wet  = (s * longint'(cur_makeup) + 32768) >>> 16;
		mixf = (cur_mix > MIX_ONE) ? longint'(MIX_ONE) : longint'(cur_mix);
		o    = x + (((wet - x) * mixf + 32768) >>> 16);
		if (o > longint'(S_MAX)) begin
			o = longint'(S_MAX);
		end
		if (o < longint'(S_MIN)) begin
			o = longint'(S_MIN);
		end
		return o[stc_pkg::SAMPLE_BITS-1:0];
	endfunction

	function automatic sample_t pick_sample();
		int kind;
		kind = $urandom_range(9);
		if (kind == 0) begin
			case ($urandom_range(4))
				0: return S_MAX;
				1: return S_MIN;
				2: return '0;
				3: return sample_t'(1);
				default: return '1;
			endcase
		end
		if (kind <= 3) begin
			return sample_t'(int'($urandom_range(131071)) - 65536);
		end
		return sample_t'($urandom());
	endfunction

	task automatic send_pair(
		input stc_pkg::in_word_t  w,
		input logic               typed,
		input stc_pkg::out_word_t fixed
	);
		int                 gap;
		stc_pkg::out_word_t e;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!in_ready);
		if (typed) begin
			e = fixed;
		end else begin
			e.left_out  = clip_sample(w.left_in);
			e.right_out = clip_sample(w.right_in);
		end
		shaped_q.push_back(e);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (shaped_q.size() != 0) @(posedge clk);
		repeat (stc_pkg::LANE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic load_gains(
		input cfg_data_t d,
		input cfg_data_t mk,
		input cfg_data_t mx
	);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= stc_pkg::REG_DRIVE_GAIN;
		cfg_data  <= d;
		@(posedge clk);
		cfg_index <= stc_pkg::REG_MAKEUP_GAIN;
		cfg_data  <= mk;
		@(posedge clk);
		cfg_index <= stc_pkg::REG_WET_MIX;
		cfg_data  <= mx;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data  <= cfg_data_t'($urandom());
		@(posedge clk);
		cfg_we     <= 1'b0;
		cur_drive  = d[stc_pkg::DRIVE_BITS-1:0];
		cur_makeup = mk[stc_pkg::MAKEUP_BITS-1:0];
		cur_mix    = mx[stc_pkg::MIX_BITS-1:0];
	endtask

	initial begin
		clip_case_t         c;
		stc_pkg::in_word_t  w;
		stc_pkg::out_word_t fixed;
		cfg_data_t          d;
		cfg_data_t          mk;
		cfg_data_t          mx;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_word   = '0;
		out_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = stc_pkg::REG_DRIVE_GAIN;
		cfg_data  = '0;
		fixed     = '0;
		build_tanh_table();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (cases[i]) begin
			c = cases[i];
			if (c.drive != cur_drive || c.makeup != cur_makeup || c.mix != cur_mix) begin
				load_gains(cfg_data_t'(c.drive), cfg_data_t'(c.makeup), cfg_data_t'(c.mix));
			end
			w.left_in       = c.left_smp;
			w.right_in      = c.right_smp;
			fixed.left_out  = c.want_left;
			fixed.right_out = c.want_right;
			send_pair(w, c.typed, fixed);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					d  = cfg_data_t'(DRIVE_RESET);
					mk = cfg_data_t'(MAKEUP_RESET);
					mx = cfg_data_t'(MIX_ONE);
				end
				1: begin
					d  = cfg_data_t'($urandom_range(262143));
					mk = cfg_data_t'($urandom_range(262143));
					mx = cfg_data_t'($urandom_range(65536));
				end
				2: begin
					d  = cfg_data_t'(DRIVE_MAX);
					mk = cfg_data_t'($urandom_range(131071));
					mx = cfg_data_t'($urandom_range(131071));
				end
				3: begin
					d  = cfg_data_t'($urandom_range(131071));
					mk = cfg_data_t'(MAKEUP_MAX);
					mx = cfg_data_t'(MIX_ONE);
				end
				4: begin
					d  = cfg_data_t'($urandom_range(196608));
					mk = cfg_data_t'($urandom_range(98304));
					mx = '0;
				end
				default: begin
					d  = cfg_data_t'($urandom());
					mk = cfg_data_t'($urandom());
					mx = cfg_data_t'($urandom_range(65536));
				end
			endcase
			load_gains(d, mk, mx);
			send_idle_pct  = (ph % 4 == 1) ? 54 : (ph % 4 == 3) ? 30 : 0;
			recv_stall_pct = (ph % 4 == 2) ? 54 : (ph % 4 == 3) ? 30 : 0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// long output hold-off while words keep coming
				if (ph == 0 && n == 40) begin
					hold_req = 1'b1;
				end
				w.left_in  = pick_sample();
				w.right_in = pick_sample();
				send_pair(w, 1'b0, fixed);
			end
		end

		drain();
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (shaped_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 100) begin
					$error("output word %h with nothing pending", out_word);
				end
			end else begin
				want = shaped_q.pop_front();
				if (out_word.left_out !== want.left_out) begin
					mismatches++;
					if (mismatches <= 100) begin
						$error("left_out expected %0d actual %0d", want.left_out,
						       out_word.left_out);
					end
				end
				if (out_word.right_out !== want.right_out) begin
					mismatches++;
					if (mismatches <= 100) begin
						$error("right_out expected %0d actual %0d", want.right_out,
						       out_word.right_out);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
